@@ sv/bmc_pkg.sv @@
// ----------------------------------------------------------------------------
// Binary mask centroid package
// Shared widths, register indexes and interface types of the centroid core.
// ----------------------------------------------------------------------------
package bmc_pkg;

   // Fixed field widths of the ports.
   localparam int PIXEL_W    = 16;
   localparam int EXT_W      = 13;
   localparam int DIMS_W     = 3;
   localparam int AXIS_W     = 2;
   localparam int CENT_W     = 20;
   localparam int SUM_W      = 44;
   localparam int COUNT_W    = 32;
   localparam int STEP_W     = 5;
   localparam int REG_DIMS   = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_3  = 3'd4;

   // Register values after reset.
   localparam logic [DIMS_W-1:0] DIMS_RESET   = 3'd2;
   localparam logic [EXT_W-1:0]  EXTENT_RESET = 13'd1;

   // Largest centroid value; larger quotients saturate to it.
   localparam logic [CENT_W-1:0] CENT_MAX = '1;

   // Occupancy of the image queue between front and back.
   typedef struct packed {
      logic full;
      logic empty;
   } bmc_qstat_type;

   // One registered result word.
   typedef struct packed {
      logic              valid;
      logic [AXIS_W-1:0] axis;
      logic [CENT_W-1:0] centroid;
      logic              empty_region;
      logic              last;
   } bmc_result_type;

endpackage

@@ sv/bmc_queue.sv @@
// ----------------------------------------------------------------------------
// Image queue
// Small FIFO of finished image totals between the pixel front and the divider.
// ----------------------------------------------------------------------------
module bmc_queue
   import bmc_pkg::*;
#(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output bmc_qstat_type    status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata        = entry_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == CNT_W'(DEPTH));
   assign status.empty = (fill_ff == '0);

endmodule

@@ sv/bmc_front.sv @@
// ----------------------------------------------------------------------------
// Pixel front
// Holds the configuration, walks the raster coordinates and accumulates the
// per-axis coordinate sums and member count, one pixel per cycle while accept is high.
// ----------------------------------------------------------------------------
module bmc_front
   import bmc_pkg::*;
#(
   parameter int LANES       = 4,
   parameter int EXTENT_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [PIXEL_W-1:0]            pixel,
   input  logic                          csr_write_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   output logic                          push,
   output logic [LANES-1:0][SUM_W-1:0]   snap_sums,
   output logic [COUNT_W-1:0]            snap_count,
   output logic [DIMS_W-1:0]             snap_dims
);

   localparam int E_W    = (EXT_W > EXTENT_BITS + 1) ? EXT_W : EXTENT_BITS + 1;
   localparam int SUM_XW = SUM_W + 1;

   logic [DIMS_W-1:0]      dim_ff;
   logic [EXT_W-1:0]       ext_ff  [REG_DIMS];
   logic [EXTENT_BITS-1:0] cnt_ff  [LANES];
   logic [EXTENT_BITS-1:0] cnt_in  [LANES];
   logic [SUM_W-1:0]       sum_ff  [LANES];
   logic [SUM_XW-1:0]      sum_add [LANES];
   logic [E_W-1:0]         top_w   [LANES];
   logic [E_W-1:0]         ext_w   [LANES];
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [DIMS_W-1:0]      dims;
   logic [E_W-1:0]         ext_lim;
   logic                   member;
   logic                   carry;

   assign ext_lim = E_W'(1) << EXTENT_BITS;
   assign member  = |pixel;

   always_comb begin
      dims = dim_ff;
      if (dims == '0) begin
         dims = DIMS_W'(1);
      end
      if (dims > DIMS_W'(LANES)) begin
         dims = DIMS_W'(LANES);
      end
   end

   // The raster walk: an axis advances only when every faster axis wraps.
   always_comb begin
      carry = 1'b1;
      for (int a = 0; a < LANES; a++) begin
         ext_w[a] = E_W'(ext_ff[a]);
         if (ext_w[a] == '0) begin
            ext_w[a] = E_W'(1);
         end
         if (ext_w[a] > ext_lim) begin
            ext_w[a] = ext_lim;
         end
         top_w[a]   = ext_w[a] - E_W'(1);
         sum_add[a] = {1'b0, sum_ff[a]} + SUM_XW'(cnt_ff[a]);
         snap_sums[a] = sum_ff[a];
         if (member && (a < dims)) begin
            snap_sums[a] = sum_add[a][SUM_W] ? '1 : sum_add[a][SUM_W-1:0];
         end
         cnt_in[a] = cnt_ff[a];
         if ((a < dims) && carry) begin
            if (E_W'(cnt_ff[a]) >= top_w[a]) begin
               cnt_in[a] = '0;
            end else begin
               cnt_in[a] = cnt_ff[a] + EXTENT_BITS'(1);
               carry     = 1'b0;
            end
         end
      end
      count_in = count_ff;
      if (member && (count_ff != '1)) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   assign push       = accept && carry;
   assign snap_count = count_in;
   assign snap_dims  = dims;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff   <= DIMS_RESET;
         count_ff <= '0;
         for (int r = 0; r < REG_DIMS; r++) begin
            ext_ff[r] <= EXTENT_RESET;
         end
         for (int a = 0; a < LANES; a++) begin
            cnt_ff[a] <= '0;
            sum_ff[a] <= '0;
         end
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_DIM_COUNT: dim_ff    <= csr_wdata[DIMS_W-1:0];
               CSR_EXTENT_0:  ext_ff[0] <= csr_wdata;
               CSR_EXTENT_1:  ext_ff[1] <= csr_wdata;
               CSR_EXTENT_2:  ext_ff[2] <= csr_wdata;
               CSR_EXTENT_3:  ext_ff[3] <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            if (carry) begin
               count_ff <= '0;
               for (int a = 0; a < LANES; a++) begin
                  cnt_ff[a] <= '0;
                  sum_ff[a] <= '0;
               end
            end else begin
               count_ff <= count_in;
               for (int a = 0; a < LANES; a++) begin
                  cnt_ff[a] <= cnt_in[a];
                  sum_ff[a] <= snap_sums[a];
               end
            end
         end
      end
   end

endmodule

@@ sv/bmc_back.sv @@
// ----------------------------------------------------------------------------
// Centroid back end
// Divides each axis sum of a queued image by its member count, one quotient
// bit per cycle, and registers one result word per axis.
// ----------------------------------------------------------------------------
module bmc_back
   import bmc_pkg::*;
#(
   parameter int LANES     = 4,
   parameter int FRAC_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bmc_qstat_type               qstat,
   input  logic [LANES-1:0][SUM_W-1:0] head_sums,
   input  logic [COUNT_W-1:0]          head_count,
   input  logic [DIMS_W-1:0]           head_dims,
   output logic                        pop,
   output bmc_result_type              result
);

   localparam int AX_W = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int NW   = SUM_W + FRAC_BITS;
   localparam int HW   = NW - CENT_W;
   localparam int CW   = (HW > COUNT_W) ? HW : COUNT_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOAD = 3'b010,
      ST_DIV  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [AX_W-1:0]   axis_ff, axis_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [CENT_W-1:0] low_ff, low_in;
   logic [CENT_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   bmc_result_type    res_ff, res_in;

   logic [NW-1:0]      dividend;
   logic [CW-1:0]      hi_ext;
   logic [CW-1:0]      cnt_ext;
   logic [COUNT_W:0]   trial;
   logic [COUNT_W:0]   diff;
   logic               fits;
   logic [CENT_W-1:0]  quot_next;
   logic [DIMS_W-1:0]  axis_p1;
   logic               last_axis;
   logic               emit;
   logic [CENT_W-1:0]  emit_cent;
   logic               emit_empty;

   assign dividend  = NW'(head_sums[axis_ff]) << FRAC_BITS;
   assign hi_ext    = CW'(dividend[NW-1:CENT_W]);
   assign cnt_ext   = CW'(head_count);
   assign trial     = {rem_ff, low_ff[CENT_W-1]};
   assign diff      = trial - {1'b0, head_count};
   assign fits      = (trial >= {1'b0, head_count});
   assign quot_next = {quot_ff[CENT_W-2:0], fits};
   assign axis_p1   = DIMS_W'(axis_ff) + DIMS_W'(1);
   assign last_axis = (axis_p1 == head_dims);

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      quot_in    = quot_ff;
      step_in    = step_ff;
      emit       = 1'b0;
      emit_cent  = '0;
      emit_empty = 1'b0;
      pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               axis_in  = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (head_count == '0) begin
               emit       = 1'b1;
               emit_empty = 1'b1;
            end else if (hi_ext >= cnt_ext) begin
               // Quotient does not fit the result field.
               emit      = 1'b1;
               emit_cent = CENT_MAX;
            end else begin
               rem_in   = hi_ext[COUNT_W-1:0];
               low_in   = dividend[CENT_W-1:0];
               quot_in  = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            low_in  = {low_ff[CENT_W-2:0], 1'b0};
            quot_in = quot_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CENT_W - 1)) begin
               emit      = 1'b1;
               emit_cent = quot_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (emit) begin
         if (last_axis) begin
            pop      = 1'b1;
            state_in = ST_IDLE;
         end else begin
            axis_in  = axis_ff + AX_W'(1);
            state_in = ST_LOAD;
         end
      end
      res_in.valid        = emit;
      res_in.axis         = AXIS_W'(axis_ff);
      res_in.centroid     = emit_cent;
      res_in.empty_region = emit_empty;
      res_in.last         = last_axis;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_ff.valid <= res_in.valid;
      end
      axis_ff               <= axis_in;
      rem_ff                <= rem_in;
      low_ff                <= low_in;
      quot_ff               <= quot_in;
      step_ff               <= step_in;
      res_ff.axis           <= res_in.axis;
      res_ff.centroid       <= res_in.centroid;
      res_ff.empty_region   <= res_in.empty_region;
      res_ff.last           <= res_in.last;
   end

   assign result = res_ff;

endmodule

@@ sv/binary_mask_centroid_core.sv @@
// ----------------------------------------------------------------------------
// Binary mask centroid core
// Centroid of the nonzero pixels of an image of up to four dimensions.
// ----------------------------------------------------------------------------
// Usage. Pixels enter in raster order, axis 0 fastest, one word per cycle:
// a word is taken at a rising edge where start is high and busy is low. The
// extents and the dimension count are set through the csr_ port, one write
// per cycle with no handshake, and are meant to be written between images.
// After the last pixel of an image the core delivers one result word per
// active axis, axes 0 upward, each shown for exactly one cycle with rsp_valid
// high; the last word of the image carries rsp_last. The receiver cannot stall.
// Throughput: one pixel per clock inside an image while busy is low. The image
// totals go into a two-entry queue, and a serial divider works them off at one
// quotient bit per cycle; an empty region or a saturated quotient skips the
// division. The front keeps taking pixels of the next image meanwhile; busy
// rises only while both queue entries hold finished images still waiting for
// the divider. Reset clears the coordinate walk, the sums, the queue and the
// divider, and loads two dimensions with all extents 1.
// ----------------------------------------------------------------------------
module binary_mask_centroid_core
   import bmc_pkg::*;
#(
   parameter int MAX_DIMS    = 4,
   parameter int EXTENT_BITS = 12,
   parameter int FRAC_BITS   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [PIXEL_W-1:0]    req_pixel,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   output logic [AXIS_W-1:0]     rsp_axis,
   output logic [CENT_W-1:0]     rsp_centroid,
   output logic                  rsp_empty_region,
   output logic                  rsp_last
);

   // Only as many axes as the register map has can ever be active.
   localparam int LANES   = (MAX_DIMS < REG_DIMS) ? MAX_DIMS : REG_DIMS;
   localparam int ENTRY_W = LANES * SUM_W + COUNT_W + DIMS_W;

   logic                        accept;
   logic                        push;
   logic                        pop;
   logic [LANES-1:0][SUM_W-1:0] snap_sums;
   logic [COUNT_W-1:0]          snap_count;
   logic [DIMS_W-1:0]           snap_dims;
   logic [LANES-1:0][SUM_W-1:0] head_sums;
   logic [COUNT_W-1:0]          head_count;
   logic [DIMS_W-1:0]           head_dims;
   logic [ENTRY_W-1:0]          head_entry;
   bmc_qstat_type               qstat;
   bmc_result_type              result;

   // A full queue holds off pixels, so a finishing image always finds room.
   assign busy   = qstat.full;
   assign accept = start && !busy;

   bmc_front #(
      .LANES       (LANES),
      .EXTENT_BITS (EXTENT_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pixel        (req_pixel),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .push         (push),
      .snap_sums    (snap_sums),
      .snap_count   (snap_count),
      .snap_dims    (snap_dims)
   );

   bmc_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (2)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wdata  ({snap_sums, snap_count, snap_dims}),
      .pop    (pop),
      .rdata  (head_entry),
      .status (qstat)
   );

   assign {head_sums, head_count, head_dims} = head_entry;

   bmc_back #(
      .LANES     (LANES),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head_sums  (head_sums),
      .head_count (head_count),
      .head_dims  (head_dims),
      .pop        (pop),
      .result     (result)
   );

   assign rsp_valid        = result.valid;
   assign rsp_axis         = result.axis;
   assign rsp_centroid     = result.centroid;
   assign rsp_empty_region = result.empty_region;
   assign rsp_last         = result.last;

endmodule

@@ sv/bmc_checker.sv @@
// ----------------------------------------------------------------------------
// Centroid core checker
// Port-level properties of the centroid core, bound to the top level.
// ----------------------------------------------------------------------------
module bmc_checker
   import bmc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic [PIXEL_W-1:0]    req_pixel,
   input logic                  csr_write_en,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata,
   input logic                  rsp_valid,
   input logic [AXIS_W-1:0]     rsp_axis,
   input logic [CENT_W-1:0]     rsp_centroid,
   input logic                  rsp_empty_region,
   input logic                  rsp_last
);

   // An empty region reports a zero centroid.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_region |-> rsp_centroid == '0)
      else $error("empty region with nonzero centroid");

   // Axis 3 is the highest axis and so always closes the image.
   a_top_axis_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_axis == 2'd3 |-> rsp_last)
      else $error("axis 3 word without last");

   // Emptiness is a property of the image, not of one axis.
   a_empty_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last ##2 rsp_valid |-> rsp_empty_region == $past(rsp_empty_region, 2))
      else $error("empty flag changed within an image");

   // Reset empties the queue, so busy is low in the first cycle after it.
   a_reset_idle: assert property (@(posedge clock)
      $fell(reset) |-> !busy && !rsp_valid)
      else $error("busy or result right after reset");

endmodule

bind binary_mask_centroid_core bmc_checker u_bmc_checker (.*);

@@ test/binary_mask_centroid_core_tb.sv @@
// ----------------------------------------------------------------------------
// Binary mask centroid core testbench
// Streams pixel words through binary_mask_centroid_core under many extent and
// dimension settings. Every result word is checked against the words typed
// into the directed table or a centroid predictor kept in the bench. A short
// directed table comes first, then random images with random sender gaps.
// ----------------------------------------------------------------------------
module binary_mask_centroid_core_tb;
   import bmc_pkg::*;

   // Widths and limits of the default core configuration.
   localparam int COORD_W      = 12;
   localparam int FRAC_BITS    = 8;
   localparam int EXTENT_MAX   = 4096;
   localparam int HALF_PERIOD  = 2;
   localparam int DRAIN_CYCLES = 120;
   localparam int RANDOM_ITEMS = 310;
   localparam int LIMIT_TIME   = 2_400_000;

   // One result word as the core shows it on the rsp_ ports.
   typedef struct packed {
      logic [AXIS_W-1:0] axis;
      logic [CENT_W-1:0] centroid;
      logic              empty_region;
      logic              last;
   } centroid_word_type;

   localparam centroid_word_type NO_WORD = '0;

   typedef enum {ROW_CSR, ROW_PIXEL} row_kind_type;

   // One row of the directed table. A pixel row with n_typed above zero
   // carries its expected words, read straight off the definition; all other
   // pixel rows are checked against the predictor.
   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] wdata;
      logic [PIXEL_W-1:0]    pixel;
      int                    n_typed;
      centroid_word_type     typed0;
      centroid_word_type     typed1;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start;
   logic                  busy;
   logic [PIXEL_W-1:0]    req_pixel;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  rsp_valid;
   logic [AXIS_W-1:0]     rsp_axis;
   logic [CENT_W-1:0]     rsp_centroid;
   logic                  rsp_empty_region;
   logic                  rsp_last;

   binary_mask_centroid_core DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_pixel        (req_pixel),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_axis         (rsp_axis),
      .rsp_centroid     (rsp_centroid),
      .rsp_empty_region (rsp_empty_region),
      .rsp_last         (rsp_last)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Predictor state: a mirror of the registers and of the image totals.
   logic [DIMS_W-1:0]  cfg_dims;
   logic [EXT_W-1:0]   cfg_extent [REG_DIMS];
   logic [COORD_W-1:0] coord [REG_DIMS];
   logic [SUM_W-1:0]   coord_sum [REG_DIMS];
   logic [COUNT_W-1:0] member_cnt;
   centroid_word_type  step_words [REG_DIMS];

   // Words still owed by the core, oldest first.
   centroid_word_type  expected_words [$];
   centroid_word_type  due_word;
   stim_row_type       stim_table [$];
   int                 error_count = 0;
   int                 sender_idle_pct = 0;

   // A dimension count of zero acts as one, and anything above four as four.
   function automatic int active_axes();
      if (cfg_dims == 0) return 1;
      if (cfg_dims > REG_DIMS) return REG_DIMS;
      return int'(cfg_dims);
   endfunction

   // Highest coordinate along an axis after the extent has been clipped to
   // the range 1 to 4096.
   function automatic logic [COORD_W-1:0] axis_last(input int a);
      int e;
      e = int'(cfg_extent[a]);
      if (e == 0) e = 1;
      if (e > EXTENT_MAX) e = EXTENT_MAX;
      return COORD_W'(e - 1);
   endfunction

   // Folds one pixel into the totals and advances the raster walk. On the
   // last pixel of an image it fills step_words with one word per active axis,
   // clears the totals and returns the number of words.
   function automatic int centroid_step(input logic [PIXEL_W-1:0] px);
      int          dims;
      int          a;
      int          n;
      bit          carry;
      logic [SUM_W:0] s;
      logic [63:0] q;
      dims  = active_axes();
      carry = 1'b1;
      n     = 0;
      if (px != '0) begin
         for (a = 0; a < dims; a++) begin
            s = {1'b0, coord_sum[a]} + (SUM_W + 1)'(coord[a]);
            coord_sum[a] = s[SUM_W] ? '1 : s[SUM_W-1:0];
         end
         if (member_cnt != '1) member_cnt++;
      end
      for (a = 0; a < dims && carry; a++) begin
         if (coord[a] >= axis_last(a)) begin
            coord[a] = '0;
         end else begin
            coord[a]++;
            carry = 1'b0;
         end
      end
      if (!carry) return 0;
      for (a = 0; a < dims; a++) begin
         step_words[n].axis         = AXIS_W'(a);
         step_words[n].empty_region = (member_cnt == '0);
         step_words[n].last         = (a == dims - 1);
         step_words[n].centroid     = '0;
         if (member_cnt != '0) begin
            q = (64'(coord_sum[a]) << FRAC_BITS) / 64'(member_cnt);
            step_words[n].centroid = (q > 64'(CENT_MAX)) ? CENT_MAX : q[CENT_W-1:0];
         end
         n++;
      end
      for (a = 0; a < REG_DIMS; a++) begin
         coord[a]     = '0;
         coord_sum[a] = '0;
      end
      member_cnt = '0;
      return n;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH at %0t: %s is 0x%0h, 0x%0h was due", $time, what, got, want);
      error_count++;
   endtask

   // The receiver cannot stall, so every strobed word is taken at the edge
   // that ends its cycle and compared with the oldest word owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            report_mismatch("result word with none owed, centroid", rsp_centroid, '0);
         end else begin
            due_word = expected_words.pop_front();
            if (rsp_axis !== due_word.axis)
               report_mismatch("axis", rsp_axis, due_word.axis);
            if (rsp_centroid !== due_word.centroid)
               report_mismatch("centroid", rsp_centroid, due_word.centroid);
            if (rsp_empty_region !== due_word.empty_region)
               report_mismatch("empty_region", rsp_empty_region, due_word.empty_region);
            if (rsp_last !== due_word.last)
               report_mismatch("last", rsp_last, due_word.last);
         end
      end
   end

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] data);
      stim_row_type r;
      r.kind  = ROW_CSR;
      r.index = idx;
      r.wdata = data;
      stim_table.push_back(r);
   endfunction

   function automatic void add_pixel(input logic [PIXEL_W-1:0] px, input int n_typed,
                                     input centroid_word_type w0,
                                     input centroid_word_type w1);
      stim_row_type r;
      r.kind    = ROW_PIXEL;
      r.pixel   = px;
      r.n_typed = n_typed;
      r.typed0  = w0;
      r.typed1  = w1;
      stim_table.push_back(r);
   endfunction

   // Writes one register; the write lands at the next rising edge. The write
   // enable is lowered by whoever drives the bench next.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      if (idx == CSR_DIM_COUNT)
         cfg_dims = data[DIMS_W-1:0];
      else if (idx <= CSR_EXTENT_3)
         cfg_extent[idx - CSR_EXTENT_0] = data;
   endtask

   // Offers one pixel word after a random gap and holds it until the core
   // takes it. Start stays high afterwards so that a word which follows at
   // once goes out with no bubble; callers that pause lower it first.
   task automatic send_pixel(input logic [PIXEL_W-1:0] px, input int n_typed,
                             input centroid_word_type w0, input centroid_word_type w1,
                             output int n_words);
      int k;
      csr_write_en <= 1'b0;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (busy);
      n_words = centroid_step(px);
      if (n_typed == 0) begin
         for (k = 0; k < n_words; k++) expected_words.push_back(step_words[k]);
      end else begin
         expected_words.push_back(w0);
         if (n_typed > 1) expected_words.push_back(w1);
      end
   endtask

   // Registers change only once every owed word has come out and the divider
   // has had time to finish.
   task automatic wait_idle();
      start        <= 1'b0;
      csr_write_en <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Hard stop in case the core hangs.
   initial begin
      #(LIMIT_TIME);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int                    n_words;
      int                    rand_items;
      int                    phase_no;
      int                    dims_raw;
      int                    eff;
      int                    n_img;
      int                    density;
      int                    pix_in_img;
      int                    mid_at;
      int                    a;
      int                    i;
      bit                    mid_pending;
      logic [PIXEL_W-1:0]    px;
      logic [CSR_DATA_W-1:0] ext;

      start        <= 1'b0;
      req_pixel    <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;

      // The predictor starts from the register values after reset.
      cfg_dims = DIMS_RESET;
      for (a = 0; a < REG_DIMS; a++) begin
         cfg_extent[a] = EXTENT_RESET;
         coord[a]      = '0;
         coord_sum[a]  = '0;
      end
      member_cnt = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table. After reset there are two axes of extent one, so each
      // pixel is an image of its own: a member at the origin, then an empty
      // region.
      add_pixel(16'hFFFF, 2, {2'd0, 20'd0, 1'b0, 1'b0}, {2'd1, 20'd0, 1'b0, 1'b1});
      add_pixel(16'h0000, 2, {2'd0, 20'd0, 1'b1, 1'b0}, {2'd1, 20'd0, 1'b1, 1'b1});
      // A row of four with members at 1 and 3 averages to 2.0.
      add_csr(CSR_DIM_COUNT, 13'd1);
      add_csr(CSR_EXTENT_0, 13'd4);
      add_pixel(16'h0000, 0, NO_WORD, NO_WORD);
      add_pixel(16'h0001, 0, NO_WORD, NO_WORD);
      add_pixel(16'h0000, 0, NO_WORD, NO_WORD);
      add_pixel(16'h8000, 1, {2'd0, 20'd512, 1'b0, 1'b1}, NO_WORD);
      // A single member at the origin is not an empty region.
      add_pixel(16'h0001, 0, NO_WORD, NO_WORD);
      add_pixel(16'h0000, 0, NO_WORD, NO_WORD);
      add_pixel(16'h0000, 0, NO_WORD, NO_WORD);
      add_pixel(16'h0000, 1, {2'd0, 20'd0, 1'b0, 1'b1}, NO_WORD);
      // Zero dimensions act as one and a zero extent acts as one.
      add_csr(CSR_DIM_COUNT, 13'd0);
      add_csr(CSR_EXTENT_0, 13'd0);
      add_pixel(16'h0007, 1, {2'd0, 20'd0, 1'b0, 1'b1}, NO_WORD);
      // Seven dimensions act as four.
      add_csr(CSR_DIM_COUNT, 13'd7);
      add_csr(CSR_EXTENT_0, 13'd2);
      add_csr(CSR_EXTENT_1, 13'd1);
      add_csr(CSR_EXTENT_2, 13'd1);
      add_csr(CSR_EXTENT_3, 13'd2);
      add_pixel(16'h5555, 0, NO_WORD, NO_WORD);
      add_pixel(16'hAAAA, 0, NO_WORD, NO_WORD);
      add_pixel(16'h0000, 0, NO_WORD, NO_WORD);
      add_pixel(16'h0001, 0, NO_WORD, NO_WORD);
      // The extent shrinks in the middle of an image: the counter, already
      // past the new top, wraps on the next pixel and closes the image.
      add_csr(CSR_DIM_COUNT, 13'd1);
      add_csr(CSR_EXTENT_0, 13'd8);
      add_pixel(16'h0000, 0, NO_WORD, NO_WORD);
      add_pixel(16'h00FF, 0, NO_WORD, NO_WORD);
      add_pixel(16'h0000, 0, NO_WORD, NO_WORD);
      add_pixel(16'hFF00, 0, NO_WORD, NO_WORD);
      add_pixel(16'h0000, 0, NO_WORD, NO_WORD);
      add_csr(CSR_EXTENT_0, 13'd3);
      add_pixel(16'hFFFF, 0, NO_WORD, NO_WORD);

      sender_idle_pct = 27;
      for (i = 0; i < stim_table.size(); i++) begin
         if (stim_table[i].kind == ROW_CSR) begin
            if (i == 0 || stim_table[i-1].kind != ROW_CSR) wait_idle();
            write_reg(stim_table[i].index, stim_table[i].wdata);
         end else begin
            send_pixel(stim_table[i].pixel, stim_table[i].n_typed,
                       stim_table[i].typed0, stim_table[i].typed1, n_words);
         end
      end

      // Random phases. Each phase loads a fresh setting and streams a few
      // small images; the sender gap rate cycles through none, heavy, none
      // and moderate. Axes in use get small extents so that images stay
      // short, while unused axes get any value at all.
      rand_items = 0;
      phase_no   = 0;
      while (rand_items < RANDOM_ITEMS) begin
         wait_idle();
         case (phase_no % 4)
            1: begin
               sender_idle_pct = 52;
            end
            3: begin
               sender_idle_pct = 27;
            end
            default: begin
               sender_idle_pct = 0;
            end
         endcase
         dims_raw = $urandom_range(0, 7);
         eff = (dims_raw == 0) ? 1 : ((dims_raw > REG_DIMS) ? REG_DIMS : dims_raw);
         // Upper data bits are dropped by the three-bit dimension register.
         write_reg(CSR_DIM_COUNT,
                   {(CSR_DATA_W - DIMS_W)'($urandom_range(0, 1023)), DIMS_W'(dims_raw)});
         for (a = 0; a < REG_DIMS; a++) begin
            if (a < eff)
               ext = CSR_DATA_W'($urandom_range(0, (eff >= 3) ? 3 : 6));
            else
               ext = CSR_DATA_W'($urandom_range(0, 8191));
            write_reg(CSR_IDX_W'(CSR_EXTENT_0 + a), ext);
         end
         // Now and then a write to an index past the last register, which
         // must leave the setting alone.
         if ($urandom_range(0, 2) == 0)
            write_reg(CSR_IDX_W'(CSR_EXTENT_3 + 1 + $urandom_range(0, 2)),
                      CSR_DATA_W'($urandom_range(0, 8191)));

         mid_pending = ($urandom_range(0, 3) == 0);
         mid_at      = $urandom_range(1, 3);
         n_img       = $urandom_range(2, 6);
         repeat (n_img) begin
            case ($urandom_range(0, 4))
               0: begin
                  density = 0;
               end
               1: begin
                  density = 15;
               end
               2: begin
                  density = 50;
               end
               3: begin
                  density = 85;
               end
               default: begin
                  density = 100;
               end
            endcase
            pix_in_img = 0;
            do begin
               // Extents of the axes in use change partway into an image.
               if (mid_pending && pix_in_img == mid_at) begin
                  mid_pending = 1'b0;
                  wait_idle();
                  for (a = 0; a < eff; a++)
                     write_reg(CSR_IDX_W'(CSR_EXTENT_0 + a),
                               CSR_DATA_W'($urandom_range(0, 3)));
               end
               if ($urandom_range(0, 99) < density)
                  px = ($urandom_range(0, 7) == 0) ? '1 : PIXEL_W'($urandom_range(1, 65535));
               else
                  px = '0;
               send_pixel(px, 0, NO_WORD, NO_WORD, n_words);
               rand_items++;
               pix_in_img++;
            end while (n_words == 0);
         end
         phase_no++;
      end

      // Let the last images drain, then watch for stray words.
      start        <= 1'b0;
      csr_write_en <= 1'b0;
      i = 0;
      while (expected_words.size() != 0 && i < 20000) begin
         @(posedge clock);
         i++;
      end
      if (expected_words.size() != 0)
         report_mismatch("result words never delivered, count", expected_words.size(), 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
